>>> src/slq_pkg.sv
// ----------------------------------------------------------------------------
// slq_pkg
// Shared types and constants for the sparkline level quantizer.
// ----------------------------------------------------------------------------
package slq_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned MAX_GLYPHS_DEF  = 64;
  localparam int unsigned MAX_SAMPLES_DEF = 64;

  // Input item kind
  typedef enum logic {
    KIND_GLYPH  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_TABLE = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_OFFSET,
    S_MULT,
    S_DIV,
    S_GREAD,
    S_PUT,
    S_ERR
  } state_t;

endpackage

>>> src/slq_if.sv
// ----------------------------------------------------------------------------
// slq_in_if / slq_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface slq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [slq_pkg::DATA_W-1:0] value;
  logic                       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

interface slq_out_if;
  logic                       valid;
  logic                       ready;
  logic [slq_pkg::DATA_W-1:0] glyph;
  logic                       last_res;
  logic [1:0]                 status;

  modport source (output valid, output glyph, output last_res, output status, input ready);
  modport sink   (input valid, input glyph, input last_res, input status, output ready);
endinterface

>>> src/sparkline_level_quantizer.sv
// ----------------------------------------------------------------------------
// sparkline_level_quantizer
// Maps a buffered set of samples onto a table of glyph words.
// ----------------------------------------------------------------------------
// Glyph transactions and every sample but the last of a set are taken one per
// cycle while the block is idle. The last sample starts the emit pass: each
// buffered sample gives one result through sample read, offset, multiply,
// one restoring-divider step per index bit, glyph read and an output load
// that waits for a free output register; when all samples are equal the
// divide steps are skipped. An error set gives a single result, loaded once
// the output register is free. New input is taken as soon as the last result
// sits in the output register. Both stores are simple dual-port RAMs (one
// write port, one registered read port); no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module sparkline_level_quantizer #(
  parameter int unsigned MAX_GLYPHS  = slq_pkg::MAX_GLYPHS_DEF,
  parameter int unsigned MAX_SAMPLES = slq_pkg::MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  slq_in_if.sink    items,
  slq_out_if.source results
);
  import slq_pkg::*;

  localparam int unsigned GW  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int unsigned GCW = $clog2(MAX_GLYPHS + 1);
  localparam int unsigned SW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned SCW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned PW  = DATA_W + GW;
  localparam int unsigned DCW = $clog2(GW + 1);

  localparam logic [GCW-1:0]    GLYPH_FULL  = GCW'(MAX_GLYPHS);
  localparam logic [SCW-1:0]    SAMPLE_FULL = SCW'(MAX_SAMPLES);
  localparam logic [DATA_W-1:0] MIN_INIT    = '1;

  // Storage
  logic [DATA_W-1:0] glyph_mem  [MAX_GLYPHS];
  logic [DATA_W-1:0] sample_mem [MAX_SAMPLES];
  logic [DATA_W-1:0] g_rdata;
  logic [DATA_W-1:0] s_rdata;

  // Control and set state
  state_t            state, state_next;
  logic [GCW-1:0]    glyph_count;
  logic              table_loading;
  logic [SCW-1:0]    sample_count;
  logic [DATA_W-1:0] run_min;
  logic [DATA_W-1:0] run_max;
  logic              overflow_seen;
  logic [SCW-1:0]    emit_idx;
  status_t           err_status;

  // Datapath
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] offset;
  logic [DATA_W-1:0] rem;
  logic [GW-1:0]     dlo;
  logic [GW-1:0]     quot;
  logic [DCW-1:0]    div_cnt;

  // Output register
  logic              out_vld;
  logic [DATA_W-1:0] out_glyph;
  logic              out_last;
  status_t           out_status;

  // Combinational helpers
  logic              acc;
  logic              is_sample;
  logic              g_start;
  logic [GCW-1:0]    g_idx;
  logic              g_room;
  logic              s_room;
  logic              ovf_now;
  logic              set_end;
  logic              set_err;
  logic [GW-1:0]     nm1;
  logic [PW-1:0]     product;
  logic [DATA_W:0]   trial;
  logic              ge;
  logic [SCW-1:0]    idx_inc;
  logic              is_final;
  logic              out_free;
  logic              load_out;

  assign items.ready = (state == S_IDLE);
  assign acc         = items.valid && items.ready;
  assign is_sample   = (items.kind == KIND_SAMPLE);

  assign g_start = !table_loading;
  assign g_idx   = g_start ? '0 : glyph_count;
  assign g_room  = (g_idx < GLYPH_FULL);
  assign s_room  = (sample_count < SAMPLE_FULL);
  assign ovf_now = overflow_seen || !s_room;
  assign set_end = acc && is_sample && items.last;
  assign set_err = ovf_now || (glyph_count == '0);

  assign nm1      = GW'(glyph_count - GCW'(1));
  assign product  = PW'(offset) * PW'(nm1);
  assign trial    = {rem, dlo[GW-1]};
  assign ge       = (trial >= {1'b0, span});
  assign idx_inc  = emit_idx + SCW'(1);
  assign is_final = (idx_inc == sample_count);
  assign out_free = !out_vld || results.ready;

  // Glyph store: write on glyph transactions, read at the computed level
  always_ff @(posedge clk) begin
    if (acc && !is_sample && g_room) begin
      glyph_mem[g_idx[GW-1:0]] <= items.value;
    end
    g_rdata <= glyph_mem[quot];
  end

  // Sample store: write on sample transactions, read at the emit index
  always_ff @(posedge clk) begin
    if (acc && is_sample && s_room) begin
      sample_mem[sample_count[SW-1:0]] <= items.value;
    end
    s_rdata <= sample_mem[emit_idx[SW-1:0]];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output load
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (set_end) begin
          state_next = set_err ? S_ERR : S_READ;
        end
      end
      S_READ:   state_next = S_OFFSET;
      S_OFFSET: state_next = S_MULT;
      S_MULT: begin
        state_next = (span == '0) ? S_GREAD : S_DIV;
      end
      S_DIV: begin
        if (div_cnt == DCW'(1)) begin
          state_next = S_GREAD;
        end
      end
      S_GREAD:  state_next = S_PUT;
      S_PUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = is_final ? S_IDLE : S_READ;
        end
      end
      S_ERR: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Table and set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_count   <= '0;
      table_loading <= 1'b0;
      sample_count  <= '0;
      run_min       <= MIN_INIT;
      run_max       <= '0;
      overflow_seen <= 1'b0;
      emit_idx      <= '0;
      err_status    <= STATUS_OK;
    end else begin
      if (acc && !is_sample) begin
        glyph_count   <= g_room ? (g_idx + GCW'(1)) : g_idx;
        table_loading <= !items.last;
        if (!g_room) begin
          overflow_seen <= 1'b1;
        end
      end else if (acc) begin
        table_loading <= 1'b0;
        emit_idx      <= '0;
        if (items.last && set_err) begin
          // error set: report and drop the set right away
          err_status    <= ovf_now ? STATUS_OVERFLOW : STATUS_NO_TABLE;
          sample_count  <= '0;
          run_min       <= MIN_INIT;
          run_max       <= '0;
          overflow_seen <= 1'b0;
        end else if (s_room) begin
          sample_count <= sample_count + SCW'(1);
          if (items.value > run_max) begin
            run_max <= items.value;
          end
          if (items.value < run_min) begin
            run_min <= items.value;
          end
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      // advance the emit pass; clear the set after its final result
      if (load_out && (state == S_PUT)) begin
        if (is_final) begin
          sample_count  <= '0;
          run_min       <= MIN_INIT;
          run_max       <= '0;
          overflow_seen <= 1'b0;
        end else begin
          emit_idx <= idx_inc;
        end
      end
    end
  end

  // Level datapath: offset, scale by N-1, restoring divide by span
  always_ff @(posedge clk) begin
    case (state)
      S_OFFSET: begin
        offset <= s_rdata - run_min;
        span   <= run_max - run_min;
      end
      S_MULT: begin
        rem     <= product[PW-1:GW];
        dlo     <= product[GW-1:0];
        div_cnt <= DCW'(GW);
        if (span == '0) begin
          quot <= nm1;
        end
      end
      S_DIV: begin
        rem     <= ge ? DATA_W'(trial - {1'b0, span}) : trial[DATA_W-1:0];
        quot    <= GW'({quot, ge});
        dlo     <= dlo << 1;
        div_cnt <= div_cnt - DCW'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load_out) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_ERR) begin
        out_glyph  <= '0;
        out_last   <= 1'b1;
        out_status <= err_status;
      end else begin
        out_glyph  <= g_rdata;
        out_last   <= is_final;
        out_status <= STATUS_OK;
      end
    end
  end

  assign results.valid    = out_vld;
  assign results.glyph    = out_glyph;
  assign results.last_res = out_last;
  assign results.status   = out_status;

endmodule

>>> sim/sparkline_level_quantizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparkline_level_quantizer_test
// Self-checking bench for the sparkline level quantizer. Glyph tables and
// sample sets are pushed through the input channel. An in-bench model
// predicts each glyph or error status, and a checker compares each result
// transaction with the oldest prediction. Both channels idle at random, and
// one long receiver hold fills the block until its input stalls.
// ----------------------------------------------------------------------------
module sparkline_level_quantizer_test;
  import slq_pkg::*;

  localparam int unsigned N_GLYPH_MAX  = MAX_GLYPHS_DEF;
  localparam int unsigned N_SAMPLE_MAX = MAX_SAMPLES_DEF;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 25;
  localparam int unsigned TAIL_CYCLES  = 40;

  // Shapes of random sample sets
  typedef enum logic [1:0] {
    SPREAD_WIDE,
    SPREAD_NARROW,
    SPREAD_FLAT,
    SPREAD_RAILS
  } spread_t;

  typedef struct packed {
    logic [DATA_W-1:0] glyph;
    logic              last_res;
    status_t           status;
  } level_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slq_in_if  items_if ();
  slq_out_if results_if ();

  sparkline_level_quantizer dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  // Idle controls and bookkeeping
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatches     = 0;
  int unsigned items_sent     = 0;

  // Predictor state
  logic [DATA_W-1:0] glyph_words  [N_GLYPH_MAX];
  int unsigned       n_glyphs     = 0;
  bit                table_open   = 1'b0;
  logic [DATA_W-1:0] held_samples [N_SAMPLE_MAX];
  int unsigned       n_held       = 0;
  logic [DATA_W-1:0] lo_seen      = '1;
  logic [DATA_W-1:0] hi_seen      = '0;
  bit                spilled      = 1'b0;
  level_res_t        levels_due [$];
  level_res_t        head_due;

  // Update the predictor with one accepted input transaction
  task automatic predict_levels(input kind_t kind, input logic [DATA_W-1:0] value,
                                input logic last);
    logic [DATA_W-1:0] off32;
    logic [DATA_W-1:0] span32;
    logic [63:0]       idx;
    level_res_t        r;
    if (kind == KIND_GLYPH) begin
      if (!table_open) begin
        n_glyphs   = 0;
        table_open = 1'b1;
      end
      if (n_glyphs < N_GLYPH_MAX) begin
        glyph_words[n_glyphs] = value;
        n_glyphs++;
      end else begin
        spilled = 1'b1;
      end
      if (last) table_open = 1'b0;
    end else begin
      table_open = 1'b0;
      if (n_held < N_SAMPLE_MAX) begin
        held_samples[n_held] = value;
        n_held++;
        if (value > hi_seen) hi_seen = value;
        if (value < lo_seen) lo_seen = value;
      end else begin
        spilled = 1'b1;
      end
      if (last) begin
        if (spilled) begin
          r = '{glyph: '0, last_res: 1'b1, status: STATUS_OVERFLOW};
          levels_due.push_back(r);
        end else if (n_glyphs == 0) begin
          r = '{glyph: '0, last_res: 1'b1, status: STATUS_NO_TABLE};
          levels_due.push_back(r);
        end else begin
          span32 = hi_seen - lo_seen;
          for (int i = 0; i < n_held; i++) begin
            off32 = held_samples[i] - lo_seen;
            if (span32 == 0)
              idx = n_glyphs - 1;
            else
              idx = ({32'b0, off32} * 64'(n_glyphs - 1)) / {32'b0, span32};
            r = '{glyph: glyph_words[idx], last_res: (i == n_held - 1), status: STATUS_OK};
            levels_due.push_back(r);
          end
        end
        n_held  = 0;
        lo_seen = '1;
        hi_seen = '0;
        spilled = 1'b0;
      end
    end
  endtask

  // Offer one input transaction and wait until it is taken
  task automatic send_item(input kind_t kind, input logic [DATA_W-1:0] value,
                           input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.kind  <= kind;
    items_if.value <= value;
    items_if.last  <= last;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    predict_levels(kind, value, last);
    items_sent++;
  endtask

  // Result ready: long holds on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_reqs != holds_served) begin
      holds_served     <= hold_reqs;
      hold_left        <= HOLD_CYCLES;
      results_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left        <= hold_left - 1;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (levels_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual glyph %h last %b status %0d",
                 $time, results_if.glyph, results_if.last_res, results_if.status);
        mismatches++;
      end else begin
        head_due = levels_due.pop_front();
        if (results_if.glyph !== head_due.glyph) begin
          $display("%0t: glyph: expected %h, actual %h", $time, head_due.glyph,
                   results_if.glyph);
          mismatches++;
        end
        if (results_if.last_res !== head_due.last_res) begin
          $display("%0t: last_res: expected %b, actual %b", $time, head_due.last_res,
                   results_if.last_res);
          mismatches++;
        end
        if (results_if.status !== head_due.status) begin
          $display("%0t: status: expected %0d, actual %0d", $time, head_due.status,
                   results_if.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sets with no table loaded; an overflowing set beats the missing table
  task automatic test_missing_table();
    for (int i = 0; i <= N_SAMPLE_MAX; i++)
      send_item(KIND_SAMPLE, $urandom(), i == N_SAMPLE_MAX);
    send_item(KIND_SAMPLE, 32'h0000_0000, 1'b0);
    send_item(KIND_SAMPLE, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Table sizes, sample extremes, flat sets and open-ended tables
  task automatic test_table_shapes();
    send_item(KIND_GLYPH, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_SAMPLE, 32'h0000_0000, 1'b0);
    send_item(KIND_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_SAMPLE, 32'h0000_0007, 1'b1);
    send_item(KIND_GLYPH, 32'h0000_0000, 1'b0);
    send_item(KIND_GLYPH, 32'hA5A5_A5A5, 1'b0);
    send_item(KIND_GLYPH, 32'h5A5A_5A5A, 1'b0);
    send_item(KIND_GLYPH, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_SAMPLE, 32'h0000_0000, 1'b0);
    send_item(KIND_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_SAMPLE, 32'h8000_0000, 1'b0);
    send_item(KIND_SAMPLE, 32'h5555_5555, 1'b1);
    // flat set and single-sample set pick the top glyph
    send_item(KIND_SAMPLE, 32'h0000_0009, 1'b0);
    send_item(KIND_SAMPLE, 32'h0000_0009, 1'b1);
    send_item(KIND_SAMPLE, 32'h1234_5678, 1'b1);
    // table without a last mark is closed by the first sample
    send_item(KIND_GLYPH, 32'h0000_0011, 1'b0);
    send_item(KIND_GLYPH, 32'h0000_0022, 1'b0);
    send_item(KIND_SAMPLE, 32'h0000_0001, 1'b0);
    send_item(KIND_SAMPLE, 32'h0000_0002, 1'b1);
    // a glyph after a closed table starts a new one
    send_item(KIND_GLYPH, 32'h0000_0033, 1'b0);
    send_item(KIND_GLYPH, 32'h0000_0044, 1'b1);
    send_item(KIND_GLYPH, 32'h0000_0055, 1'b1);
    send_item(KIND_SAMPLE, 32'hDEAD_BEEF, 1'b0);
    send_item(KIND_SAMPLE, 32'h0000_0001, 1'b1);
  endtask

  // Glyph store overflow: error on next set, first glyphs kept as the table
  task automatic test_store_overflow();
    for (int i = 0; i <= N_GLYPH_MAX; i++)
      send_item(KIND_GLYPH, $urandom(), i == N_GLYPH_MAX);
    for (int i = 0; i < 3; i++)
      send_item(KIND_SAMPLE, $urandom(), i == 2);
    for (int i = 0; i < 8; i++)
      send_item(KIND_SAMPLE, $urandom(), i == 7);
  endtask

  // Long receiver hold while full sets keep coming
  task automatic test_backpressure();
    src_idle_pct   <= 0;
    sink_stall_pct <= 0;
    for (int i = 0; i < 8; i++)
      send_item(KIND_GLYPH, $urandom(), i == 7);
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < N_SAMPLE_MAX; i++)
      send_item(KIND_SAMPLE, $urandom(), i == N_SAMPLE_MAX - 1);
    for (int i = 0; i < 20; i++)
      send_item(KIND_SAMPLE, $urandom(), i == 19);
  endtask

  // One random table (sometimes) and one random sample set
  task automatic play_random_set();
    int unsigned       n_tbl;
    int unsigned       n_set;
    bit                close_tbl;
    spread_t           spread;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] v;
    if ($urandom_range(99) < 35) begin
      n_tbl     = ($urandom_range(9) == 0) ? N_GLYPH_MAX : $urandom_range(12, 1);
      close_tbl = ($urandom_range(7) != 0);
      for (int i = 0; i < n_tbl; i++)
        send_item(KIND_GLYPH, $urandom(), close_tbl && (i == n_tbl - 1));
    end
    n_set  = ($urandom_range(14) == 0) ? N_SAMPLE_MAX : $urandom_range(10, 1);
    spread = spread_t'($urandom_range(3));
    base   = $urandom();
    for (int i = 0; i < n_set; i++) begin
      case (spread)
        SPREAD_WIDE:   v = $urandom();
        SPREAD_NARROW: v = base + $urandom_range(15);
        SPREAD_FLAT:   v = base;
        default: begin
          case ($urandom_range(2))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom();
          endcase
        end
      endcase
      send_item(KIND_SAMPLE, v, i == n_set - 1);
    end
  endtask

  // Random sets across the idle phases
  task automatic test_random_sets();
    int unsigned phase_end;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
        1: begin src_idle_pct <= 79; sink_stall_pct <= 0;  end
        2: begin src_idle_pct <= 0;  sink_stall_pct <= 79; end
        default: begin src_idle_pct <= 32; sink_stall_pct <= 32; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) play_random_set();
    end
  endtask

  initial begin
    items_if.valid   <= 1'b0;
    items_if.kind    <= KIND_GLYPH;
    items_if.value   <= '0;
    items_if.last    <= 1'b0;
    rst              <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_missing_table();
    test_table_shapes();
    test_store_overflow();
    test_backpressure();
    test_random_sets();

    // drain outstanding results, then let the block settle
    items_if.valid <= 1'b0;
    src_idle_pct   <= 0;
    sink_stall_pct <= 0;
    do @(posedge clk); while (levels_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && levels_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sparkline_level_quantizer.f
src/slq_pkg.sv
src/slq_if.sv
src/sparkline_level_quantizer.sv
sim/sparkline_level_quantizer_test.sv
